[sv/apr_pkg.sv]
// ----------------------------------------------------------------------------
// Aging page replacement package
// Shared types, field widths and default sizes for the frame table block.
// ----------------------------------------------------------------------------
package apr_pkg;

  localparam int NUM_FRAMES_DEF = 4096;
  localparam int AGE_BITS_DEF   = 8;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 12;
  localparam int ROOT_W     = 44;
  localparam int VA_W       = 39;
  localparam int PAGE_SHIFT = 12;
  localparam int VPN_W      = VA_W - PAGE_SHIFT;
  localparam int COUNT_W    = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_AGE    = 2'd2,
    CMD_SELECT = 2'd3
  } cmd_t;

  // One classified command as it travels from the front end to the back end.
  typedef struct packed {
    cmd_t              cmd;
    logic              in_range;
    logic [IDX_W-1:0]  idx;
    logic [ROOT_W-1:0] root;
    logic [VPN_W-1:0]  vpn;
    logic              pte_ok;
    logic              acc;
  } item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_DRAIN,
    ST_VICTIM
  } back_state_t;

endpackage

[sv/aging_page_replacement.sv]
// ----------------------------------------------------------------------------
// Aging page replacement
// Table of physical frames with used marks, aging counters, owner roots and
// virtual page numbers; picks the least recently used eligible frame.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Moves
//  in_      input      in_valid/in_ready    one command transaction
//  out_     output     out_valid/out_ready  one result transaction per command
//
// Add, remove and age report pass through the back end in order: a queue pop
// that issues the registered memory read, then a write-back that loads the
// result register. A command whose frame is out of range is answered from
// the pop itself. Select scans the whole frame memory through its single
// read port, then drains the read pipeline and loads the result register.
// After reset a clearing pass writes every frame, during which in_ready is
// held low. A two-entry queue keeps taking commands while the result register
// waits on out_ready; the back end stalls only when the result register is
// still full.
// ----------------------------------------------------------------------------
module aging_page_replacement #(
  parameter int NUM_FRAMES = apr_pkg::NUM_FRAMES_DEF,
  parameter int AGE_BITS   = apr_pkg::AGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [apr_pkg::CMD_W-1:0]   in_cmd,
  input  logic [apr_pkg::IDX_W-1:0]   in_frame_index,
  input  logic [apr_pkg::ROOT_W-1:0]  in_table_root,
  input  logic [apr_pkg::VA_W-1:0]    in_virt_addr,
  input  logic                        in_pte_ok,
  input  logic                        in_accessed,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [apr_pkg::COUNT_W-1:0] out_used_count,
  output logic                        out_victim_found,
  output logic [apr_pkg::IDX_W-1:0]   out_victim_index,
  output logic [apr_pkg::ROOT_W-1:0]  out_victim_table,
  output logic [apr_pkg::VA_W-1:0]    out_victim_va,
  output logic                        out_clear_accessed
);
  import apr_pkg::*;

  // Front end to queue.
  logic  push_valid;
  logic  push_ready;
  item_t push_item;

  // Queue to back end.
  logic  pop_valid;
  logic  pop;
  item_t pop_item;

  // The back end holds off the front end until the table has been cleared.
  logic  init_done;

  apr_front #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_frame_index(in_frame_index),
    .in_table_root (in_table_root),
    .in_virt_addr  (in_virt_addr),
    .in_pte_ok     (in_pte_ok),
    .in_accessed   (in_accessed),
    .init_done     (init_done),
    .push_ready    (push_ready),
    .push_valid    (push_valid),
    .push_item     (push_item)
  );

  apr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  apr_back #(
    .NUM_FRAMES(NUM_FRAMES),
    .AGE_BITS  (AGE_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (pop_valid),
    .q_pop             (pop),
    .q_item            (pop_item),
    .init_done         (init_done),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_used_count    (out_used_count),
    .out_victim_found  (out_victim_found),
    .out_victim_index  (out_victim_index),
    .out_victim_table  (out_victim_table),
    .out_victim_va     (out_victim_va),
    .out_clear_accessed(out_clear_accessed)
  );

endmodule

[sv/apr_front.sv]
// ----------------------------------------------------------------------------
// Aging page replacement front end
// Accepts commands, checks the frame range and strips the page offset.
// ----------------------------------------------------------------------------
module apr_front #(
  parameter int NUM_FRAMES = apr_pkg::NUM_FRAMES_DEF
) (
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [apr_pkg::CMD_W-1:0]  in_cmd,
  input  logic [apr_pkg::IDX_W-1:0]  in_frame_index,
  input  logic [apr_pkg::ROOT_W-1:0] in_table_root,
  input  logic [apr_pkg::VA_W-1:0]   in_virt_addr,
  input  logic                       in_pte_ok,
  input  logic                       in_accessed,
  input  logic                       init_done,
  input  logic                       push_ready,
  output logic                       push_valid,
  output apr_pkg::item_t             push_item
);
  import apr_pkg::*;

  assign in_ready   = push_ready && init_done;
  assign push_valid = in_valid && in_ready;

  always_comb begin
    push_item          = '0;
    push_item.cmd      = cmd_t'(in_cmd);
    push_item.in_range = (32'(in_frame_index) < 32'(NUM_FRAMES));
    push_item.idx      = in_frame_index;
    push_item.root     = in_table_root;
    push_item.vpn      = in_virt_addr[VA_W-1:PAGE_SHIFT];
    push_item.pte_ok   = in_pte_ok;
    push_item.acc      = in_accessed;
  end

endmodule

[sv/apr_queue.sv]
// ----------------------------------------------------------------------------
// Aging page replacement command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module apr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  apr_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop,
  output apr_pkg::item_t pop_item
);
  import apr_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_item   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push_valid && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push_valid) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[sv/apr_back.sv]
// ----------------------------------------------------------------------------
// Aging page replacement back end
// Frame table memory, read-modify-write sequencer, victim scan and result
// register.
// ----------------------------------------------------------------------------
module apr_back #(
  parameter int NUM_FRAMES = apr_pkg::NUM_FRAMES_DEF,
  parameter int AGE_BITS   = apr_pkg::AGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  apr_pkg::item_t              q_item,
  output logic                        init_done,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [apr_pkg::COUNT_W-1:0] out_used_count,
  output logic                        out_victim_found,
  output logic [apr_pkg::IDX_W-1:0]   out_victim_index,
  output logic [apr_pkg::ROOT_W-1:0]  out_victim_table,
  output logic [apr_pkg::VA_W-1:0]    out_victim_va,
  output logic                        out_clear_accessed
);
  import apr_pkg::*;

  localparam int IW     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CW     = $clog2(NUM_FRAMES + 1);
  localparam int EW     = 1 + AGE_BITS + ROOT_W + VPN_W;
  localparam int VPN_LO = 0;
  localparam int ROOT_LO = VPN_W;
  localparam int AGE_LO = VPN_W + ROOT_W;
  localparam int USED_B = EW - 1;
  localparam logic [IW-1:0] LAST = IW'(NUM_FRAMES - 1);

  back_state_t state_r, state_nxt;
  item_t       cur_r;

  logic [EW-1:0] mem [NUM_FRAMES];
  logic [EW-1:0] rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          we;
  logic [IW-1:0] wa;
  logic [EW-1:0] wd;

  logic [IW-1:0] clr_r;
  logic [IW-1:0] scan_r;
  logic          cmp_valid_r;
  logic [IW-1:0] cmp_idx_r;

  logic                have_r;
  logic [IW-1:0]       best_idx_r;
  logic [AGE_BITS-1:0] best_age_r;
  logic [ROOT_W-1:0]   best_root_r;
  logic [VPN_W-1:0]    best_vpn_r;

  logic [CW-1:0] cnt_r, cnt_nxt;

  logic out_free;
  logic load_out;
  logic res_found;
  logic [IW-1:0] res_idx;
  logic [ROOT_W-1:0] res_root;
  logic [VPN_W-1:0] res_vpn;
  logic res_clr;

  logic                out_valid_r;
  logic [CW-1:0]       o_cnt_r;
  logic                o_found_r;
  logic [IW-1:0]       o_idx_r;
  logic [ROOT_W-1:0]   o_root_r;
  logic [VPN_W-1:0]    o_vpn_r;
  logic                o_clr_r;

  logic [IW+IDX_W-1:0] cur_ext, q_ext;
  logic [IW-1:0]       cur_addr, q_addr;

  logic                old_used;
  logic [AGE_BITS-1:0] old_age;
  logic [ROOT_W-1:0]   old_root;
  logic                scan_elig;

  logic [CW+COUNT_W-1:0] cnt_ext;
  logic [IW+IDX_W-1:0]   vidx_ext;

  assign cur_ext  = {{IW{1'b0}}, cur_r.idx};
  assign q_ext    = {{IW{1'b0}}, q_item.idx};
  assign cur_addr = cur_ext[IW-1:0];
  assign q_addr   = q_ext[IW-1:0];

  assign old_used = rd_data_r[USED_B];
  assign old_age  = rd_data_r[AGE_LO +: AGE_BITS];
  assign old_root = rd_data_r[ROOT_LO +: ROOT_W];
  assign scan_elig = old_used && (old_root != '0);

  assign out_free  = !out_valid_r || out_ready;
  assign init_done = (state_r != ST_CLEAR);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid && out_free) begin
          if (q_item.cmd == CMD_SELECT) state_nxt = ST_SCAN;
          else if (q_item.in_range)     state_nxt = ST_RMW;
        end
      end
      ST_RMW:   state_nxt = ST_IDLE;
      ST_SCAN: begin
        if (scan_r == LAST) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_VICTIM;
      ST_VICTIM: state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop     = 1'b0;
    rd_addr   = cur_addr;
    we        = 1'b0;
    wa        = cur_addr;
    wd        = '0;
    load_out  = 1'b0;
    res_found = 1'b0;
    res_idx   = '0;
    res_root  = '0;
    res_vpn   = '0;
    res_clr   = 1'b0;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        wa = clr_r;
      end
      ST_IDLE: begin
        rd_addr = q_addr;
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_item.cmd != CMD_SELECT && !q_item.in_range) begin
            load_out = 1'b1;
          end
        end
      end
      ST_RMW: begin
        load_out = 1'b1;
        unique case (cur_r.cmd)
          CMD_ADD: begin
            we = 1'b1;
            wd = {1'b1, {AGE_BITS{1'b0}}, cur_r.root, cur_r.vpn};
            if (!old_used) cnt_nxt = cnt_r + CW'(1);
          end
          CMD_REMOVE: begin
            if (old_used) begin
              we = 1'b1;
              if (cnt_r != '0) cnt_nxt = cnt_r - CW'(1);
            end
          end
          CMD_AGE: begin
            if (old_used && old_root != '0) begin
              we = 1'b1;
              if (!cur_r.pte_ok) begin
                if (cnt_r != '0) cnt_nxt = cnt_r - CW'(1);
              end else begin
                wd = rd_data_r;
                wd[AGE_LO +: AGE_BITS] = {cur_r.acc, old_age[AGE_BITS-1:1]};
                res_clr = cur_r.acc;
              end
            end
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        rd_addr = scan_r;
      end
      ST_DRAIN: ;
      ST_VICTIM: begin
        load_out = 1'b1;
        if (have_r) begin
          we        = 1'b1;
          wa        = best_idx_r;
          res_found = 1'b1;
          res_idx   = best_idx_r;
          res_root  = best_root_r;
          res_vpn   = best_vpn_r;
          if (cnt_r != '0) cnt_nxt = cnt_r - CW'(1);
        end
      end
      default: ;
    endcase
  end

  // Frame table memory.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      scan_r      <= '0;
      cmp_valid_r <= 1'b0;
      have_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cmp_valid_r <= (state_r == ST_SCAN);
      if (state_r == ST_CLEAR) clr_r <= clr_r + IW'(1);
      if (q_pop) begin
        scan_r <= '0;
        have_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        scan_r <= scan_r + IW'(1);
      end
      if (cmp_valid_r && scan_elig && (!have_r || old_age < best_age_r)) begin
        have_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_item;
    cmp_idx_r <= scan_r;
    if (cmp_valid_r && scan_elig && (!have_r || old_age < best_age_r)) begin
      best_idx_r  <= cmp_idx_r;
      best_age_r  <= old_age;
      best_root_r <= old_root;
      best_vpn_r  <= rd_data_r[VPN_LO +: VPN_W];
    end
    if (load_out) begin
      o_cnt_r   <= cnt_nxt;
      o_found_r <= res_found;
      o_idx_r   <= res_idx;
      o_root_r  <= res_root;
      o_vpn_r   <= res_vpn;
      o_clr_r   <= res_clr;
    end
  end

  assign cnt_ext  = {{COUNT_W{1'b0}}, o_cnt_r};
  assign vidx_ext = {{IDX_W{1'b0}}, o_idx_r};

  assign out_valid          = out_valid_r;
  assign out_used_count     = cnt_ext[COUNT_W-1:0];
  assign out_victim_found   = o_found_r;
  assign out_victim_index   = vidx_ext[IDX_W-1:0];
  assign out_victim_table   = o_root_r;
  assign out_victim_va      = {o_vpn_r, {PAGE_SHIFT{1'b0}}};
  assign out_clear_accessed = o_clr_r;

endmodule

[sv/apr_checker.sv]
// ----------------------------------------------------------------------------
// Aging page replacement checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module apr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [apr_pkg::COUNT_W-1:0] out_used_count,
  input logic                        out_victim_found,
  input logic [apr_pkg::IDX_W-1:0]   out_victim_index,
  input logic [apr_pkg::ROOT_W-1:0]  out_victim_table,
  input logic [apr_pkg::VA_W-1:0]    out_victim_va,
  input logic                        out_clear_accessed
);
  import apr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_used_count)
      && $stable(out_victim_index) && $stable(out_victim_found))
    else $error("result changed while stalled");

  a_no_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_victim_found |-> out_victim_index == '0
      && out_victim_table == '0 && out_victim_va == '0)
    else $error("victim fields set without a victim");

  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clear_accessed |-> !out_victim_found)
    else $error("clear request and victim in one result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind aging_page_replacement apr_checker u_apr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_used_count    (out_used_count),
  .out_victim_found  (out_victim_found),
  .out_victim_index  (out_victim_index),
  .out_victim_table  (out_victim_table),
  .out_victim_va     (out_victim_va),
  .out_clear_accessed(out_clear_accessed)
);
